// ===== hdl/msc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared widths, reset values and register indexes of the MBSFN subframe
// classifier.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned TTI_W      = 14;
  localparam int unsigned FRAME_W    = 11;
  localparam int unsigned SF_W       = 4;
  localparam int unsigned DIV10_W    = 16;
  localparam int unsigned PROD_W     = TTI_W + DIV10_W;
  localparam int unsigned DIV10_SHR  = 19;
  // ceil(2^19 / 10): exact quotient for every 14-bit value
  localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;

  localparam int unsigned MCH_MAP_W  = 40;
  localparam int unsigned MCCH_MAP_W = 10;
  localparam int unsigned APER_W     = 6;
  localparam int unsigned AOFF_W     = 5;
  localparam int unsigned MPER_W     = 9;
  localparam int unsigned MOFF_W     = 4;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned AREA_W     = 19;
  localparam int unsigned MAPIDX_W   = 6;

  localparam int unsigned AREA_ID_W  = 8;
  localparam int unsigned REGION_W   = 2;
  localparam int unsigned MCS_W      = 5;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [APER_W-1:0]    APER_RST   = 6'd1;
  localparam logic [MPER_W-1:0]    MPER_RST   = 9'd32;
  localparam logic [AREA_W-1:0]    AREA_RST   = 19'd256;

  localparam logic [REGION_W-1:0]  DEF_REGION = 2'd1;
  localparam logic [MCS_W-1:0]     DEF_MCS    = 5'd2;
  localparam logic [3:0]           SF_PER_FRAME = 4'd10;
  localparam int unsigned          FOUR_FRAMES  = 4;

  // mode flag bit positions
  localparam int unsigned MODE_FOUR  = 0;
  localparam int unsigned MODE_AREA  = 1;
  localparam int unsigned MODE_DMCS  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MCH_MAP      = 4'd0,
    REG_MCCH_MAP     = 4'd1,
    REG_ALLOC_PERIOD = 4'd2,
    REG_ALLOC_OFFSET = 4'd3,
    REG_MCCH_PERIOD  = 4'd4,
    REG_MCCH_OFFSET  = 4'd5,
    REG_MODE_FLAGS   = 4'd6,
    REG_AREA_PARAMS  = 4'd7
  } cfg_reg_e;

endpackage

// ===== hdl/mbsfn_subframe_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsfn_subframe_classifier_top
// Classifies a TTI as regular, MCH or MCCH subframe and returns its encoding.
// ----------------------------------------------------------------------------
// One TTI enters per cycle while in_ready_o is high; its result is registered
// in stages one, two and three and held in the stage three output register
// until taken. Stage one splits the TTI by a reciprocal multiply by ten, stage
// two forms subframe index, allocation index and the MCCH frame match, stage
// three picks the map bits and builds the result. A stage holds only while it
// is full and the stage after it holds. Configuration writes are taken every
// cycle and must be made while no TTI is in flight.
module mbsfn_subframe_classifier_top
  import msc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TTI_W-1:0]      tti_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_mbsfn_o,
  output logic                  is_mcch_o,
  output logic [AREA_ID_W-1:0]  area_id_o,
  output logic [REGION_W-1:0]   region_length_o,
  output logic [MCS_W-1:0]      mcs_o,
  output logic                  encode_o
);

  // configuration registers
  logic [MCH_MAP_W-1:0]  mch_map_q;
  logic [MCCH_MAP_W-1:0] mcch_map_q;
  logic [APER_W-1:0]     alloc_period_q;
  logic [AOFF_W-1:0]     alloc_offset_q;
  logic [MPER_W-1:0]     mcch_period_q;
  logic [MOFF_W-1:0]     mcch_offset_q;
  logic [MODE_W-1:0]     mode_flags_q;
  logic [AREA_W-1:0]     area_params_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mch_map_q      <= '0;
      mcch_map_q     <= '0;
      alloc_period_q <= APER_RST;
      alloc_offset_q <= '0;
      mcch_period_q  <= MPER_RST;
      mcch_offset_q  <= '0;
      mode_flags_q   <= '0;
      area_params_q  <= AREA_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MCH_MAP:      mch_map_q      <= cfg_data_i[MCH_MAP_W-1:0];
        REG_MCCH_MAP:     mcch_map_q     <= cfg_data_i[MCCH_MAP_W-1:0];
        REG_ALLOC_PERIOD: alloc_period_q <= cfg_data_i[APER_W-1:0];
        REG_ALLOC_OFFSET: alloc_offset_q <= cfg_data_i[AOFF_W-1:0];
        REG_MCCH_PERIOD:  mcch_period_q  <= cfg_data_i[MPER_W-1:0];
        REG_MCCH_OFFSET:  mcch_offset_q  <= cfg_data_i[MOFF_W-1:0];
        REG_MODE_FLAGS:   mode_flags_q   <= cfg_data_i[MODE_W-1:0];
        REG_AREA_PARAMS:  area_params_q  <= cfg_data_i[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;

  assign s3_en      = !s3_valid_q || out_ready_i;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // stage 1: frame number by reciprocal multiply
  logic [PROD_W-1:0]  prod;
  logic [TTI_W-1:0]   s1_tti_q;
  logic [FRAME_W-1:0] s1_frame_q;

  assign prod = PROD_W'(tti_i) * PROD_W'(DIV10_MUL);

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_tti_q   <= tti_i;
      s1_frame_q <= prod[DIV10_SHR +: FRAME_W];
    end
  end

  // stage 2: subframe index, allocation index, mcch frame match
  logic [TTI_W-1:0]    frame_x10;
  logic [TTI_W-1:0]    sf_wide;
  logic [MPER_W-1:0]   mmask;
  logic [APER_W-1:0]   amask;
  logic                mcch_frame_ok;
  logic [SF_W-1:0]     s2_sf_q;
  logic [APER_W-1:0]   s2_idx_q;
  logic                s2_mcch_ok_q;

  assign frame_x10 = {s1_frame_q, 3'b000} + {2'b00, s1_frame_q, 1'b0};
  assign sf_wide   = s1_tti_q - frame_x10;
  assign mmask     = mcch_period_q - MPER_W'(1);
  assign amask     = alloc_period_q - APER_W'(1);
  assign mcch_frame_ok =
    ((s1_frame_q & {{(FRAME_W-MPER_W){1'b0}}, mmask}) ==
     {{(FRAME_W-MOFF_W){1'b0}}, mcch_offset_q});

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_sf_q      <= sf_wide[SF_W-1:0];
      s2_idx_q     <= s1_frame_q[APER_W-1:0] & amask;
      s2_mcch_ok_q <= mcch_frame_ok;
    end
  end

  // stage 3: map lookups and result selection
  logic [15:0]            mcch_ext;
  logic [63:0]            mch_ext;
  logic                   area_cfg;
  logic                   mcch_hit;
  logic [APER_W-1:0]      diff;
  logic                   in_win;
  logic [MAPIDX_W-1:0]    bit_idx;
  logic [REGION_W-1:0]    area_region;
  logic                   mbsfn_d, mcch_d, enc_d;
  logic [AREA_ID_W-1:0]   aid_d;
  logic [REGION_W-1:0]    reg_d;
  logic [MCS_W-1:0]       mcs_d;

  assign mcch_ext    = {{(16-MCCH_MAP_W){1'b0}}, mcch_map_q};
  assign mch_ext     = {{(64-MCH_MAP_W){1'b0}}, mch_map_q};
  assign area_cfg    = mode_flags_q[MODE_AREA];
  assign mcch_hit    = area_cfg && s2_mcch_ok_q && mcch_ext[s2_sf_q];
  assign diff        = s2_idx_q - {1'b0, alloc_offset_q};
  assign in_win      = (s2_idx_q >= {1'b0, alloc_offset_q}) &&
                       (diff < APER_W'(FOUR_FRAMES));
  // (idx - offset) * 10 + sf
  assign bit_idx     = {1'b0, diff[1:0], 3'b000} + {3'b000, diff[1:0], 1'b0} +
                       {2'b00, s2_sf_q};
  assign area_region = {1'b0, area_params_q[8]} + DEF_REGION;

  always_comb begin
    mbsfn_d = 1'b0;
    mcch_d  = 1'b0;
    enc_d   = 1'b0;
    aid_d   = '0;
    reg_d   = DEF_REGION;
    mcs_d   = DEF_MCS;
    priority if (mcch_hit) begin
      mbsfn_d = 1'b1;
      mcch_d  = 1'b1;
      aid_d   = area_params_q[7:0];
      reg_d   = area_region;
      mcs_d   = area_params_q[13:9];
      enc_d   = 1'b1;
    end else if (!mode_flags_q[MODE_FOUR]) begin
      if ((s2_idx_q == {1'b0, alloc_offset_q}) && mch_ext[{2'b00, s2_sf_q}]) begin
        mbsfn_d = 1'b1;
        if (area_cfg) begin
          aid_d = area_params_q[7:0];
          reg_d = area_region;
          if (mode_flags_q[MODE_DMCS]) begin
            mcs_d = area_params_q[18:14];
            enc_d = 1'b1;
          end
        end
      end
    end else begin
      if (in_win && mch_ext[bit_idx]) begin
        mbsfn_d = 1'b1;
        if (area_cfg) begin
          aid_d = area_params_q[7:0];
          reg_d = area_region;
        end
      end
    end
  end

  logic                 is_mbsfn_q, is_mcch_q, encode_q;
  logic [AREA_ID_W-1:0] area_id_q;
  logic [REGION_W-1:0]  region_q;
  logic [MCS_W-1:0]     mcs_q;

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      is_mbsfn_q <= mbsfn_d;
      is_mcch_q  <= mcch_d;
      area_id_q  <= aid_d;
      region_q   <= reg_d;
      mcs_q      <= mcs_d;
      encode_q   <= enc_d;
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign is_mbsfn_o      = is_mbsfn_q;
  assign is_mcch_o       = is_mcch_q;
  assign area_id_o       = area_id_q;
  assign region_length_o = region_q;
  assign mcs_o           = mcs_q;
  assign encode_o        = encode_q;

endmodule

// ===== hdl/msc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks on the result channel of the subframe classifier.
// ----------------------------------------------------------------------------
module msc_checker
  import msc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 is_mbsfn_o,
  input logic                 is_mcch_o,
  input logic [AREA_ID_W-1:0] area_id_o,
  input logic [REGION_W-1:0]  region_length_o,
  input logic [MCS_W-1:0]     mcs_o,
  input logic                 encode_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_mbsfn_o) &&
      $stable(is_mcch_o) && $stable(area_id_o) && $stable(region_length_o) &&
      $stable(mcs_o) && $stable(encode_o))
    else $error("result changed while stalled");

  // regular subframe carries all defaults
  a_regular_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_mbsfn_o |-> !is_mcch_o && !encode_o &&
      (area_id_o == '0) && (region_length_o == DEF_REGION) && (mcs_o == DEF_MCS))
    else $error("regular subframe with non-default fields");

  // mcch implies an encoded mbsfn subframe
  a_mcch_encoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_mcch_o |-> is_mbsfn_o && encode_o)
    else $error("mcch subframe not encoded as mbsfn");

  a_encode_mbsfn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && encode_o |-> is_mbsfn_o)
    else $error("encode set on regular subframe");

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (region_length_o == 2'd1) || (region_length_o == 2'd2))
    else $error("region length out of range");

endmodule

bind mbsfn_subframe_classifier_top msc_checker u_msc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .is_mbsfn_o      (is_mbsfn_o),
  .is_mcch_o       (is_mcch_o),
  .area_id_o       (area_id_o),
  .region_length_o (region_length_o),
  .mcs_o           (mcs_o),
  .encode_o        (encode_o)
);
